[rtl/core/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low reset disable.
`define PCPFA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define PCPFA_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[rtl/core/pcpfa_pkg.sv]
// Shared types, codes and defaults for the per-CPU page free-list allocator.
// Depends on nothing; imported by every module of the block.
package pcpfa_pkg;

    localparam int DEF_CPU_COUNT  = 8;
    localparam int DEF_PAGE_COUNT = 1024;
    // Page size is a power of two; alignment and page numbers use shifts and masks.
    localparam int DEF_PAGE_BYTES = 4096;
    localparam int QUEUE_DEPTH    = 2;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOP_ADDRESS   = 2'd1;

    localparam logic [31:0] FIRST_ADDRESS_RESET = 32'h8000_0000;
    localparam logic [31:0] TOP_ADDRESS_RESET   = 32'h8800_0000;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Classified job handed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_BAD
    } op_t;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  cpu_id;
        logic [31:0] page_address;
    } req_t;

    typedef struct packed {
        logic [31:0] alloc_address;
        logic [1:0]  status;
    } rsp_t;

endpackage

[rtl/core/pcpfa_front.sv]
// Front end: takes requests, wraps the CPU number and checks free addresses.
// Depends on pcpfa_pkg; feeds classified jobs into pcpfa_queue.
module pcpfa_front
    import pcpfa_pkg::*;
#(
    parameter int CPU_COUNT  = DEF_CPU_COUNT,
    parameter int PAGE_COUNT = DEF_PAGE_COUNT,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES,
    localparam int CPU_W     = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1,
    localparam int PAGE_W    = $clog2(PAGE_COUNT),
    localparam int JOB_W     = $bits(op_t) + CPU_W + PAGE_W
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  req_t              s_data,
    input  logic [31:0]       first_address,
    input  logic [31:0]       top_address,
    output logic              job_valid,
    input  logic              job_ready,
    output logic [JOB_W-1:0]  job_data
);

    localparam int SH = $clog2(PAGE_BYTES);

    typedef struct packed {
        op_t               op;
        logic [CPU_W-1:0]  cpu;
        logic [PAGE_W-1:0] page;
    } job_t;

    function automatic logic [CPU_W-1:0] wrap_cpu(input logic [2:0] id);
        logic [2:0] r;
        r = id;
        for (int i = 0; i < 8; i++) begin
            if (int'(r) >= CPU_COUNT) begin
                r = r - 3'(CPU_COUNT);
            end
        end
        return CPU_W'(r);
    endfunction

    logic [32:0] base_page;
    logic [32:0] addr_page;
    logic [32:0] page_diff;
    logic        bad_addr;
    job_t        job;

    always_comb begin
        // First page of the region is first_address rounded up to a page boundary.
        base_page = 33'(first_address >> SH) + 33'(|first_address[SH-1:0]);
        addr_page = 33'(s_data.page_address >> SH);
        page_diff = addr_page - base_page;
        bad_addr  = (|s_data.page_address[SH-1:0])
                 || (s_data.page_address < first_address)
                 || (s_data.page_address >= top_address)
                 || (page_diff >= 33'(PAGE_COUNT));

        job.cpu  = wrap_cpu(s_data.cpu_id);
        job.page = page_diff[PAGE_W-1:0];
        if (s_data.req_type == REQ_FREE) begin
            job.op = bad_addr ? OP_BAD : OP_PUSH;
        end else begin
            job.op = OP_POP;
        end
    end

    assign job_data  = job;
    assign job_valid = s_valid;
    assign s_ready   = job_ready;

endmodule

[rtl/core/pcpfa_queue.sv]
// Small FIFO that decouples the classifying front end from the list back end.
// Depends on pcpfa_pkg for its default depth.
module pcpfa_queue
    import pcpfa_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_fire;
    logic             rd_fire;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_fire) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_fire && !rd_fire) begin
            count_next = count_reg + 1'b1;
        end else if (rd_fire && !wr_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/core/pcpfa_back.sv]
// Back end: per-CPU list heads, next-page memory and the result register.
// Depends on pcpfa_pkg; takes jobs from pcpfa_queue.
module pcpfa_back
    import pcpfa_pkg::*;
#(
    parameter int CPU_COUNT  = DEF_CPU_COUNT,
    parameter int PAGE_COUNT = DEF_PAGE_COUNT,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES,
    localparam int CPU_W     = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1,
    localparam int PAGE_W    = $clog2(PAGE_COUNT),
    localparam int JOB_W     = $bits(op_t) + CPU_W + PAGE_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    output logic              job_ready,
    input  logic [JOB_W-1:0]  job_data,
    input  logic [31:0]       first_address,
    output logic              m_valid,
    input  logic              m_ready,
    output rsp_t              m_data
);

    localparam int SH = $clog2(PAGE_BYTES);

    typedef struct packed {
        op_t               op;
        logic [CPU_W-1:0]  cpu;
        logic [PAGE_W-1:0] page;
    } job_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    state_t             state_reg;
    logic               m_valid_reg;
    logic               m_valid_next;
    rsp_t               m_data_reg;
    logic [PAGE_W-1:0]  head_reg [CPU_COUNT];
    logic [CPU_COUNT-1:0] head_valid_reg;
    logic [CPU_W-1:0]   src_reg;
    logic [PAGE_W-1:0]  page_reg;

    logic [PAGE_W:0]    next_mem [PAGE_COUNT];
    logic [PAGE_W:0]    rd_data_reg;

    job_t               job;
    logic               out_free;
    logic               any_valid;
    logic               rsp_load;
    logic [CPU_W-1:0]   lowest_src;
    logic [CPU_W-1:0]   steal_src;
    logic [CPU_W-1:0]   sel;
    logic [PAGE_W-1:0]  head_sel;
    logic               mem_we;
    logic               mem_re;
    logic [32:0]        base_page;
    logic [32:0]        page_sum;
    logic [31:0]        alloc_address;

    assign job       = job_data;
    assign out_free  = !m_valid_reg || m_ready;
    assign job_ready = job_valid && (state_reg == ST_IDLE) && out_free;
    assign any_valid = |head_valid_reg;

    always_comb begin
        lowest_src = '0;
        for (int i = CPU_COUNT - 1; i >= 0; i--) begin
            if (head_valid_reg[i]) begin
                lowest_src = CPU_W'(i);
            end
        end
    end

    // The own list wins; otherwise the lowest-numbered non-empty list is robbed.
    assign steal_src = head_valid_reg[job.cpu] ? job.cpu : lowest_src;
    assign sel       = (job.op == OP_PUSH) ? job.cpu : steal_src;
    assign head_sel  = head_reg[sel];
    assign mem_we    = job_ready && (job.op == OP_PUSH);
    assign mem_re    = job_ready && (job.op == OP_POP) && any_valid;

    // A result is loaded for every job except a pop that still waits on the link read.
    assign rsp_load     = (job_ready && !((job.op == OP_POP) && any_valid))
                       || ((state_reg == ST_POP) && out_free);
    assign m_valid_next = rsp_load || (m_valid_reg && !m_ready);

    always_comb begin
        base_page     = 33'(first_address >> SH) + 33'(|first_address[SH-1:0]);
        page_sum      = base_page + 33'(page_reg);
        alloc_address = {page_sum[31-SH:0], {SH{1'b0}}};
    end

    // Next-page links: valid bit above the successor page number.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            next_mem[job.page] <= {head_valid_reg[sel], head_sel};
        end
        if (mem_re) begin
            rd_data_reg <= next_mem[head_sel];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            head_valid_reg <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (job_ready) begin
                        unique case (job.op)
                            OP_PUSH: begin
                                head_reg[job.cpu]       <= job.page;
                                head_valid_reg[job.cpu] <= 1'b1;
                                m_data_reg.alloc_address <= '0;
                                m_data_reg.status        <= STATUS_OK;
                            end
                            OP_POP: begin
                                if (any_valid) begin
                                    src_reg   <= steal_src;
                                    page_reg  <= head_sel;
                                    state_reg <= ST_POP;
                                end else begin
                                    m_data_reg.alloc_address <= '0;
                                    m_data_reg.status        <= STATUS_EMPTY;
                                end
                            end
                            default: begin
                                m_data_reg.alloc_address <= '0;
                                m_data_reg.status        <= STATUS_BAD_ADDR;
                            end
                        endcase
                    end
                end
                ST_POP: begin
                    // Link read issued from ST_IDLE is now in rd_data_reg.
                    if (out_free) begin
                        head_reg[src_reg]        <= rd_data_reg[PAGE_W-1:0];
                        head_valid_reg[src_reg]  <= rd_data_reg[PAGE_W];
                        m_data_reg.alloc_address <= alloc_address;
                        m_data_reg.status        <= STATUS_OK;
                        state_reg                <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/core/per_cpu_page_free_list_allocator.sv]
// Per-CPU page free-list allocator with stealing.
// Request channel s_*: req_type, cpu_id, page_address; result channel m_*:
// alloc_address and status (ok, no free page anywhere, bad free address).
// Config channel cfg_*: index 0 writes first_address, index 1 top_address;
// other indexes are ignored. Write config only while no request is pending.
// A request accepted by the front end is written into a two-entry queue; the
// back end takes it when idle and its output register is free. Frees, rejected
// frees and empty allocations load the result register as the job is taken; a
// successful allocation loads it from ST_POP, after the registered read of the
// next-page memory. No new job is taken while an allocation waits in ST_POP for
// that read and the head update.
// Reset empties every CPU list and loads the default address window; the
// next-page memory is not cleared, so the range is filled by issuing frees.
// When m_ready is low the result waits in the output register, the queue
// fills, and s_ready drops once both queue entries are taken.
// Depends on pcpfa_pkg, pcpfa_front, pcpfa_queue, pcpfa_back, assert_macros.svh.
`include "assert_macros.svh"

module per_cpu_page_free_list_allocator
    import pcpfa_pkg::*;
#(
    parameter int CPU_COUNT  = DEF_CPU_COUNT,
    parameter int PAGE_COUNT = DEF_PAGE_COUNT,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  req_t                   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output rsp_t                   m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int PAGE_W = $clog2(PAGE_COUNT);

    typedef struct packed {
        op_t               op;
        logic [CPU_W-1:0]  cpu;
        logic [PAGE_W-1:0] page;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    logic [31:0]      first_address_reg;
    logic [31:0]      top_address_reg;
    logic             q_wr_valid;
    logic             q_wr_ready;
    logic [JOB_W-1:0] q_wr_data;
    logic             q_rd_valid;
    logic             q_rd_ready;
    logic [JOB_W-1:0] q_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_address_reg <= FIRST_ADDRESS_RESET;
            top_address_reg   <= TOP_ADDRESS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FIRST_ADDRESS: first_address_reg <= cfg_data;
                CFG_TOP_ADDRESS:   top_address_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    pcpfa_front #(
        .CPU_COUNT  (CPU_COUNT),
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .first_address (first_address_reg),
        .top_address   (top_address_reg),
        .job_valid     (q_wr_valid),
        .job_ready     (q_wr_ready),
        .job_data      (q_wr_data)
    );

    pcpfa_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    pcpfa_back #(
        .CPU_COUNT  (CPU_COUNT),
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (q_rd_valid),
        .job_ready     (q_rd_ready),
        .job_data      (q_rd_data),
        .first_address (first_address_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

    // Backpressure on the request side only comes from a full queue.
    `PCPFA_ASSERT(a_stall_means_queued, aclk, aresetn, !s_ready |-> q_rd_valid, "stall without queued job")
    // An accepted request is waiting in the queue on the next cycle.
    `PCPFA_ASSERT(a_accept_reaches_queue, aclk, aresetn, s_valid && s_ready |=> q_rd_valid, "accepted request lost")
    // Failed requests never carry an address.
    `PCPFA_ASSERT_NEVER(a_fail_no_address, aclk, aresetn, m_valid && (m_data.status != STATUS_OK) && (m_data.alloc_address != 32'd0), "address on failed request")

endmodule
